// File: design/pcf_pkg.sv
`default_nettype none
package pcf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_ENABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLUME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME  = 3'd5;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [2:0] CMD_PLAY        = 3'd0;
    localparam logic [2:0] CMD_STOP        = 3'd1;
    localparam logic [2:0] CMD_VOLUME      = 3'd2;
    localparam logic [2:0] CMD_LOOP_SINGLE = 3'd3;
    localparam logic [2:0] CMD_LOOP_OFF    = 3'd4;
    localparam logic [2:0] CMD_EQ          = 3'd5;
    localparam logic [2:0] CMD_SELECT_CARD = 3'd6;
    localparam logic [2:0] CMD_FAST_VOLUME = 3'd7;

    localparam logic [7:0] CODE_PLAY   = 8'h07;
    localparam logic [7:0] CODE_STOP   = 8'h04;
    localparam logic [7:0] CODE_VOLUME = 8'h13;
    localparam logic [7:0] CODE_LOOP   = 8'h18;
    localparam logic [7:0] CODE_EQ     = 8'h1A;
    localparam logic [7:0] CODE_CARD   = 8'h0B;

    localparam logic [7:0] ARG_ONE = 8'h01;
    localparam logic [7:0] ARG_TWO = 8'h02;
    localparam logic [15:0] EQ_MAX_CODE = 16'd4;

    localparam logic [7:0] FRAME_START = 8'hAA;
    localparam logic [7:0] ACK_FIRST   = 8'hAA;
    localparam logic [7:0] ACK_SECOND  = 8'hFF;
    localparam logic [7:0] VOLUME_NONE = 8'hFF;

    localparam logic [3:0] ATTEMPTS_MAX = 4'd15;

    localparam logic [2:0] ST_ACKED   = 3'd0;
    localparam logic [2:0] ST_FAILED  = 3'd1;
    localparam logic [2:0] ST_SENT    = 3'd2;
    localparam logic [2:0] ST_SKIPPED = 3'd3;
    localparam logic [2:0] ST_BUSY    = 3'd4;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       frame;
        logic [7:0] code;
        logic [1:0] length;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] sum;
        logic       has_status;
        logic [2:0] status;
        logic [3:0] attempts;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_state_t;

endpackage
`default_nettype wire

// File: design/pcf_chan_if.sv
`default_nettype none
interface pcf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  command;
    logic [15:0] argument;
    logic [7:0]  rx_byte;

    modport source(output valid, output opcode, output command, output argument,
                   output rx_byte, input ready);
    modport sink(input valid, input opcode, input command, input argument,
                 input rx_byte, output ready);
endinterface

interface pcf_res_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic [2:0] status;
    logic [3:0] attempts_used;

    modport source(output valid, output result_kind, output tx_byte, output frame_last,
                   output status, output attempts_used, input ready);
    modport sink(input valid, input result_kind, input tx_byte, input frame_last,
                 input status, input attempts_used, output ready);
endinterface
`default_nettype wire

// File: design/player_command_framer_with_ack_top.sv
// Command framer for a serial audio player. The front end classifies each accepted item,
// tracks the acknowledge wait, timeout and retry gap, and queues the work it causes; a
// new item is accepted every cycle while the job queue of QUEUE_DEPTH entries has room.
// The back end emits one result per cycle from the queue head through an output register
// while the receiver takes results, so a request yields between one result (status only)
// and seven results (a two-byte frame plus its status), and a receive byte or tick yields
// none unless it ends the wait or the retry gap.
`default_nettype none
module player_command_framer_with_ack_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pcf_cmd_if.sink                             cmd_in,
    pcf_res_if.source                           res_out
);

    pcf_pkg::job_push_t    push;
    pcf_pkg::queue_state_t queue_state;
    pcf_pkg::job_t         head;
    logic                  pop;

    pcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd_in      (cmd_in),
        .queue_state (queue_state),
        .push        (push)
    );

    pcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .state (queue_state),
        .head  (head),
        .pop   (pop)
    );

    pcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_state (queue_state),
        .head        (head),
        .pop         (pop),
        .res_out     (res_out)
    );

endmodule
`default_nettype wire

// File: design/pcf_front.sv
`default_nettype none
module pcf_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pcf_cmd_if.sink                             cmd_in,
    input  wire pcf_pkg::queue_state_t          queue_state,
    output pcf_pkg::job_push_t                  push
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_GAP
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       ack_match_reg, ack_match_next;
    logic [3:0] attempt_count_reg, attempt_count_next;
    logic [9:0] wait_timer_reg, wait_timer_next;
    logic [7:0] held_code_reg, held_code_next;
    logic [7:0] held_p0_reg, held_p0_next;
    logic [7:0] held_p1_reg, held_p1_next;
    logic [1:0] held_length_reg, held_length_next;
    logic [7:0] last_volume_reg, last_volume_next;

    logic       ack_enabled_reg;
    logic [3:0] max_retries_reg;
    logic [9:0] ack_timeout_reg;
    logic [9:0] retry_gap_reg;
    logic [4:0] min_volume_reg;
    logic [4:0] max_volume_reg;

    logic       accept;
    logic [7:0] req_code;
    logic [1:0] req_length;
    logic [7:0] req_p0;
    logic [7:0] req_p1;
    logic [7:0] volume;
    logic       gap_fail;
    logic [3:0] attempt_inc;

    function automatic logic [7:0] clamp_volume(input logic [15:0] a, input logic [4:0] lo,
                                                input logic [4:0] hi);
        logic [7:0] v;
        if (a < {11'd0, lo})
        begin
            v = {3'd0, lo};
        end
        else if (a > {11'd0, hi})
        begin
            v = {3'd0, hi};
        end
        else
        begin
            v = a[7:0];
        end
        return v;
    endfunction

    function automatic pcf_pkg::job_t frame_job(input logic [7:0] code, input logic [1:0] len,
                                                input logic [7:0] p0, input logic [7:0] p1);
        pcf_pkg::job_t j;
        j = '0;
        j.frame  = 1'b1;
        j.code   = code;
        j.length = len;
        j.p0     = p0;
        j.p1     = p1;
        j.sum    = pcf_pkg::FRAME_START + code + {6'd0, len} + p0 + p1;
        return j;
    endfunction

    assign cmd_in.ready = !queue_state.full;
    assign accept       = cmd_in.valid && cmd_in.ready;
    assign volume       = clamp_volume(cmd_in.argument, min_volume_reg, max_volume_reg);
    assign gap_fail     = attempt_count_reg >= max_retries_reg;
    assign attempt_inc  = (attempt_count_reg < pcf_pkg::ATTEMPTS_MAX) ?
                          attempt_count_reg + 4'd1 : attempt_count_reg;

    always_comb
    begin
        req_code   = pcf_pkg::CODE_STOP;
        req_length = 2'd1;
        req_p0     = 8'd0;
        req_p1     = 8'd0;
        case (cmd_in.command)
            pcf_pkg::CMD_PLAY:
            begin
                req_code   = pcf_pkg::CODE_PLAY;
                req_length = 2'd2;
                if (cmd_in.argument == 16'd0)
                begin
                    req_p1 = 8'd1;
                end
                else
                begin
                    req_p0 = cmd_in.argument[15:8];
                    req_p1 = cmd_in.argument[7:0];
                end
            end
            pcf_pkg::CMD_STOP:
            begin
                req_code   = pcf_pkg::CODE_STOP;
                req_length = 2'd0;
            end
            pcf_pkg::CMD_VOLUME, pcf_pkg::CMD_FAST_VOLUME:
            begin
                req_code = pcf_pkg::CODE_VOLUME;
                req_p0   = volume;
            end
            pcf_pkg::CMD_LOOP_SINGLE:
            begin
                req_code = pcf_pkg::CODE_LOOP;
                req_p0   = pcf_pkg::ARG_ONE;
            end
            pcf_pkg::CMD_LOOP_OFF:
            begin
                req_code = pcf_pkg::CODE_LOOP;
                req_p0   = pcf_pkg::ARG_TWO;
            end
            pcf_pkg::CMD_EQ:
            begin
                req_code = pcf_pkg::CODE_EQ;
                req_p0   = (cmd_in.argument > pcf_pkg::EQ_MAX_CODE) ?
                           8'd0 : cmd_in.argument[7:0];
            end
            pcf_pkg::CMD_SELECT_CARD:
            begin
                req_code = pcf_pkg::CODE_CARD;
                req_p0   = pcf_pkg::ARG_ONE;
            end
            default:
            begin
                req_code = pcf_pkg::CODE_STOP;
            end
        endcase
    end

    always_comb
    begin
        phase_next         = phase_reg;
        ack_match_next     = ack_match_reg;
        attempt_count_next = attempt_count_reg;
        wait_timer_next    = wait_timer_reg;
        held_code_next     = held_code_reg;
        held_p0_next       = held_p0_reg;
        held_p1_next       = held_p1_reg;
        held_length_next   = held_length_reg;
        last_volume_next   = last_volume_reg;
        push               = '0;

        if (accept)
        begin
            case (cmd_in.opcode)
                pcf_pkg::OP_REQUEST:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        push.valid           = 1'b1;
                        push.job.has_status  = 1'b1;
                        push.job.status      = pcf_pkg::ST_BUSY;
                    end
                    else if (cmd_in.command == pcf_pkg::CMD_FAST_VOLUME &&
                             volume == last_volume_reg)
                    begin
                        held_p0_next         = 8'd0;
                        held_p1_next         = 8'd0;
                        push.valid           = 1'b1;
                        push.job.has_status  = 1'b1;
                        push.job.status      = pcf_pkg::ST_SKIPPED;
                    end
                    else
                    begin
                        held_code_next   = req_code;
                        held_length_next = req_length;
                        held_p0_next     = req_p0;
                        held_p1_next     = req_p1;
                        if (cmd_in.command == pcf_pkg::CMD_VOLUME ||
                            cmd_in.command == pcf_pkg::CMD_FAST_VOLUME)
                        begin
                            last_volume_next = volume;
                        end
                        if (cmd_in.command == pcf_pkg::CMD_FAST_VOLUME || !ack_enabled_reg)
                        begin
                            push.valid          = 1'b1;
                            push.job            = frame_job(req_code, req_length, req_p0, req_p1);
                            push.job.has_status = 1'b1;
                            push.job.status     = pcf_pkg::ST_SENT;
                            push.job.attempts   = 4'd1;
                        end
                        else if (max_retries_reg == 4'd0)
                        begin
                            attempt_count_next  = 4'd0;
                            push.valid          = 1'b1;
                            push.job.has_status = 1'b1;
                            push.job.status     = pcf_pkg::ST_FAILED;
                        end
                        else
                        begin
                            attempt_count_next = 4'd1;
                            ack_match_next     = 1'b0;
                            wait_timer_next    = ack_timeout_reg;
                            phase_next         = PH_WAIT;
                            push.valid         = 1'b1;
                            push.job           = frame_job(req_code, req_length, req_p0, req_p1);
                        end
                    end
                end
                pcf_pkg::OP_RX_BYTE:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (ack_match_reg && cmd_in.rx_byte == pcf_pkg::ACK_SECOND)
                        begin
                            phase_next          = PH_IDLE;
                            ack_match_next      = 1'b0;
                            wait_timer_next     = 10'd0;
                            push.valid          = 1'b1;
                            push.job.has_status = 1'b1;
                            push.job.status     = pcf_pkg::ST_ACKED;
                            push.job.attempts   = attempt_count_reg;
                        end
                        else
                        begin
                            ack_match_next = (cmd_in.rx_byte == pcf_pkg::ACK_FIRST);
                        end
                    end
                end
                pcf_pkg::OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (wait_timer_reg > 10'd1)
                        begin
                            wait_timer_next = wait_timer_reg - 10'd1;
                        end
                        else if (phase_reg == PH_WAIT && retry_gap_reg != 10'd0)
                        begin
                            ack_match_next  = 1'b0;
                            phase_next      = PH_GAP;
                            wait_timer_next = retry_gap_reg;
                        end
                        else if (gap_fail)
                        begin
                            ack_match_next      = 1'b0;
                            phase_next          = PH_IDLE;
                            wait_timer_next     = 10'd0;
                            push.valid          = 1'b1;
                            push.job.has_status = 1'b1;
                            push.job.status     = pcf_pkg::ST_FAILED;
                            push.job.attempts   = attempt_count_reg;
                        end
                        else
                        begin
                            attempt_count_next = attempt_inc;
                            ack_match_next     = 1'b0;
                            wait_timer_next    = ack_timeout_reg;
                            phase_next         = PH_WAIT;
                            push.valid         = 1'b1;
                            push.job           = frame_job(held_code_reg, held_length_reg,
                                                           held_p0_reg, held_p1_reg);
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            ack_match_reg     <= 1'b0;
            attempt_count_reg <= 4'd0;
            wait_timer_reg    <= 10'd0;
            held_code_reg     <= 8'd0;
            held_p0_reg       <= 8'd0;
            held_p1_reg       <= 8'd0;
            held_length_reg   <= 2'd0;
            last_volume_reg   <= pcf_pkg::VOLUME_NONE;
            ack_enabled_reg   <= 1'b1;
            max_retries_reg   <= 4'd3;
            ack_timeout_reg   <= 10'd150;
            retry_gap_reg     <= 10'd20;
            min_volume_reg    <= 5'd0;
            max_volume_reg    <= 5'd30;
        end
        else
        begin
            phase_reg         <= phase_next;
            ack_match_reg     <= ack_match_next;
            attempt_count_reg <= attempt_count_next;
            wait_timer_reg    <= wait_timer_next;
            held_code_reg     <= held_code_next;
            held_p0_reg       <= held_p0_next;
            held_p1_reg       <= held_p1_next;
            held_length_reg   <= held_length_next;
            last_volume_reg   <= last_volume_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pcf_pkg::CFG_ACK_ENABLED: ack_enabled_reg <= cfg_wdata[0];
                    pcf_pkg::CFG_MAX_RETRIES: max_retries_reg <= cfg_wdata[3:0];
                    pcf_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata[9:0];
                    pcf_pkg::CFG_RETRY_GAP:   retry_gap_reg   <= cfg_wdata[9:0];
                    pcf_pkg::CFG_MIN_VOLUME:  min_volume_reg  <= cfg_wdata[4:0];
                    pcf_pkg::CFG_MAX_VOLUME:  max_volume_reg  <= cfg_wdata[4:0];
                    default:                  ack_enabled_reg <= ack_enabled_reg;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// File: design/pcf_queue.sv
`default_nettype none
module pcf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pcf_pkg::job_push_t    push,
    output pcf_pkg::queue_state_t      state,
    output pcf_pkg::job_t              head,
    input  wire logic                  pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    pcf_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign state.valid = count_reg != '0;
    assign state.full  = count_reg == FULL_CNT;
    assign head        = mem_reg[rd_ptr_reg];
    assign do_push     = push.valid && !state.full;
    assign do_pop      = pop && state.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: design/pcf_back.sv
`default_nettype none
module pcf_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pcf_pkg::queue_state_t queue_state,
    input  wire pcf_pkg::job_t         head,
    output logic                       pop,
    pcf_res_if.source                  res_out
);

    typedef enum logic [2:0] {
        STEP_HDR,
        STEP_CODE,
        STEP_LEN,
        STEP_P0,
        STEP_P1,
        STEP_SUM,
        STEP_STAT
    } step_t;

    step_t      step_reg, step_next, step_cur;
    logic       out_valid_reg;
    logic       kind_reg, kind_next;
    logic [7:0] tx_reg, tx_next;
    logic       last_reg, last_next;
    logic [2:0] status_reg, status_next;
    logic [3:0] attempts_reg, attempts_next;
    logic       fire;

    assign fire     = queue_state.valid && (!out_valid_reg || res_out.ready);
    assign step_cur = (!head.frame && step_reg == STEP_HDR) ? STEP_STAT : step_reg;

    always_comb
    begin
        step_next     = step_reg;
        pop           = 1'b0;
        kind_next     = pcf_pkg::KIND_TX;
        tx_next       = 8'd0;
        last_next     = 1'b0;
        status_next   = pcf_pkg::ST_ACKED;
        attempts_next = 4'd0;
        case (step_cur)
            STEP_HDR:
            begin
                tx_next   = pcf_pkg::FRAME_START;
                step_next = STEP_CODE;
            end
            STEP_CODE:
            begin
                tx_next   = head.code;
                step_next = STEP_LEN;
            end
            STEP_LEN:
            begin
                tx_next   = {6'd0, head.length};
                step_next = (head.length == 2'd0) ? STEP_SUM : STEP_P0;
            end
            STEP_P0:
            begin
                tx_next   = head.p0;
                step_next = (head.length == 2'd1) ? STEP_SUM : STEP_P1;
            end
            STEP_P1:
            begin
                tx_next   = head.p1;
                step_next = STEP_SUM;
            end
            STEP_SUM:
            begin
                tx_next   = head.sum;
                last_next = 1'b1;
                if (head.has_status)
                begin
                    step_next = STEP_STAT;
                end
                else
                begin
                    step_next = STEP_HDR;
                    pop       = fire;
                end
            end
            STEP_STAT:
            begin
                kind_next     = pcf_pkg::KIND_STATUS;
                status_next   = head.status;
                attempts_next = head.attempts;
                step_next     = STEP_HDR;
                pop           = fire;
            end
            default:
            begin
                step_next = STEP_HDR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_HDR;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            tx_reg        <= 8'd0;
            last_reg      <= 1'b0;
            status_reg    <= 3'd0;
            attempts_reg  <= 4'd0;
        end
        else if (fire)
        begin
            step_reg      <= step_next;
            out_valid_reg <= 1'b1;
            kind_reg      <= kind_next;
            tx_reg        <= tx_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
            attempts_reg  <= attempts_next;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.result_kind   = kind_reg;
    assign res_out.tx_byte       = tx_reg;
    assign res_out.frame_last    = last_reg;
    assign res_out.status        = status_reg;
    assign res_out.attempts_used = attempts_reg;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import pcf_pkg::*;

    localparam int RUN_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SEQ_PER_PHASE = 14;
    localparam int TICK_BURST    = 24;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {LINK_IDLE, LINK_WAIT, LINK_GAP} link_phase_e;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  command;
        logic [15:0] argument;
        logic [7:0]  rx_byte;
    } link_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic [2:0] status;
        logic [3:0] attempts;
    } player_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic        cmd_valid    = 1'b0;
    logic [1:0]  cmd_opcode   = '0;
    logic [2:0]  cmd_command  = '0;
    logic [15:0] cmd_argument = '0;
    logic [7:0]  cmd_rx_byte  = '0;
    logic        res_ready    = 1'b0;

    pcf_cmd_if cmd_if();
    pcf_res_if res_if();

    assign cmd_if.valid    = cmd_valid;
    assign cmd_if.opcode   = cmd_opcode;
    assign cmd_if.command  = cmd_command;
    assign cmd_if.argument = cmd_argument;
    assign cmd_if.rx_byte  = cmd_rx_byte;
    assign res_if.ready    = res_ready;

    player_command_framer_with_ack_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_in    (cmd_if),
        .res_out   (res_if)
    );

    // Register copies and player state as the predictor sees them.
    logic       reg_ack_en  = 1'b1;
    logic [3:0] reg_retries = 4'd3;
    logic [9:0] reg_timeout = 10'd150;
    logic [9:0] reg_gap     = 10'd20;
    logic [4:0] reg_min_vol = 5'd0;
    logic [4:0] reg_max_vol = 5'd30;

    link_phase_e link_phase  = LINK_IDLE;
    logic        ack_half    = 1'b0;
    logic [3:0]  attempt_cnt = '0;
    logic [9:0]  link_timer  = '0;
    logic [7:0]  frame_code  = '0;
    logic [7:0]  frame_p0    = '0;
    logic [7:0]  frame_p1    = '0;
    logic [1:0]  frame_len   = '0;
    logic [7:0]  sent_volume = VOLUME_NONE;

    link_item_t     link_items[$];
    player_result_t due_outcomes[$];
    link_item_t     on_bus;
    int             items_queued  = 0;
    int             items_taken   = 0;
    int             fault_count   = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic add_outcome(input logic kind, input logic [7:0] tx, input logic last,
                               input logic [2:0] status, input logic [3:0] attempts);
        player_result_t r;
        r.kind     = kind;
        r.tx       = tx;
        r.last     = last;
        r.status   = status;
        r.attempts = attempts;
        due_outcomes.push_back(r);
    endtask

    task automatic add_frame_bytes();
        logic [7:0] sum;
        sum = FRAME_START + frame_code + 8'(frame_len);
        add_outcome(KIND_TX, FRAME_START, 1'b0, '0, '0);
        add_outcome(KIND_TX, frame_code, 1'b0, '0, '0);
        add_outcome(KIND_TX, 8'(frame_len), 1'b0, '0, '0);
        if (frame_len >= 2'd1)
        begin
            sum = sum + frame_p0;
            add_outcome(KIND_TX, frame_p0, 1'b0, '0, '0);
        end
        if (frame_len >= 2'd2)
        begin
            sum = sum + frame_p1;
            add_outcome(KIND_TX, frame_p1, 1'b0, '0, '0);
        end
        add_outcome(KIND_TX, sum, 1'b1, '0, '0);
    endtask

    task automatic send_attempt();
        add_frame_bytes();
        if (attempt_cnt < ATTEMPTS_MAX)
            attempt_cnt = attempt_cnt + 4'd1;
        ack_half   = 1'b0;
        link_timer = reg_timeout;
        link_phase = LINK_WAIT;
    endtask

    task automatic end_of_gap();
        if (attempt_cnt >= reg_retries)
        begin
            link_phase = LINK_IDLE;
            link_timer = '0;
            add_outcome(KIND_STATUS, '0, 1'b0, ST_FAILED, attempt_cnt);
        end
        else
            send_attempt();
    endtask

    function automatic logic [7:0] clamp_volume(input logic [15:0] a);
        if (a < {11'b0, reg_min_vol})
            return {3'b0, reg_min_vol};
        if (a > {11'b0, reg_max_vol})
            return {3'b0, reg_max_vol};
        return a[7:0];
    endfunction

    task automatic predict_frames_and_status(input link_item_t it);
        logic [15:0] track;
        logic [7:0]  vol;
        logic        done;
        done = 1'b0;
        case (it.opcode)
            OP_REQUEST:
            begin
                if (link_phase != LINK_IDLE)
                    add_outcome(KIND_STATUS, '0, 1'b0, ST_BUSY, '0);
                else
                begin
                    frame_p0 = '0;
                    frame_p1 = '0;
                    case (it.command)
                        CMD_PLAY:
                        begin
                            track      = (it.argument == 16'd0) ? 16'd1 : it.argument;
                            frame_code = CODE_PLAY;
                            frame_len  = 2'd2;
                            frame_p0   = track[15:8];
                            frame_p1   = track[7:0];
                        end
                        CMD_STOP:
                        begin
                            frame_code = CODE_STOP;
                            frame_len  = 2'd0;
                        end
                        CMD_VOLUME:
                        begin
                            frame_code  = CODE_VOLUME;
                            frame_len   = 2'd1;
                            frame_p0    = clamp_volume(it.argument);
                            sent_volume = frame_p0;
                        end
                        CMD_LOOP_SINGLE:
                        begin
                            frame_code = CODE_LOOP;
                            frame_len  = 2'd1;
                            frame_p0   = ARG_ONE;
                        end
                        CMD_LOOP_OFF:
                        begin
                            frame_code = CODE_LOOP;
                            frame_len  = 2'd1;
                            frame_p0   = ARG_TWO;
                        end
                        CMD_EQ:
                        begin
                            frame_code = CODE_EQ;
                            frame_len  = 2'd1;
                            frame_p0   = (it.argument > EQ_MAX_CODE) ? 8'h00 : it.argument[7:0];
                        end
                        CMD_SELECT_CARD:
                        begin
                            frame_code = CODE_CARD;
                            frame_len  = 2'd1;
                            frame_p0   = ARG_ONE;
                        end
                        default:
                        begin
                            done = 1'b1;
                            vol  = clamp_volume(it.argument);
                            if (vol == sent_volume)
                                add_outcome(KIND_STATUS, '0, 1'b0, ST_SKIPPED, '0);
                            else
                            begin
                                frame_code  = CODE_VOLUME;
                                frame_len   = 2'd1;
                                frame_p0    = vol;
                                sent_volume = vol;
                                add_frame_bytes();
                                add_outcome(KIND_STATUS, '0, 1'b0, ST_SENT, 4'd1);
                            end
                        end
                    endcase
                    if (!done)
                    begin
                        if (!reg_ack_en)
                        begin
                            add_frame_bytes();
                            add_outcome(KIND_STATUS, '0, 1'b0, ST_SENT, 4'd1);
                        end
                        else
                        begin
                            attempt_cnt = '0;
                            if (reg_retries == 4'd0)
                                add_outcome(KIND_STATUS, '0, 1'b0, ST_FAILED, '0);
                            else
                                send_attempt();
                        end
                    end
                end
            end
            OP_RX_BYTE:
            begin
                if (link_phase == LINK_WAIT)
                begin
                    if (ack_half && it.rx_byte == ACK_SECOND)
                    begin
                        link_phase = LINK_IDLE;
                        ack_half   = 1'b0;
                        link_timer = '0;
                        add_outcome(KIND_STATUS, '0, 1'b0, ST_ACKED, attempt_cnt);
                    end
                    else
                        ack_half = (it.rx_byte == ACK_FIRST);
                end
            end
            OP_TICK:
            begin
                if (link_phase == LINK_WAIT)
                begin
                    if (link_timer > 10'd1)
                        link_timer = link_timer - 10'd1;
                    else
                    begin
                        ack_half   = 1'b0;
                        link_phase = LINK_GAP;
                        if (reg_gap == 10'd0)
                            end_of_gap();
                        else
                            link_timer = reg_gap;
                    end
                end
                else if (link_phase == LINK_GAP)
                begin
                    if (link_timer > 10'd1)
                        link_timer = link_timer - 10'd1;
                    else
                        end_of_gap();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid    <= 1'b0;
            cmd_opcode   <= '0;
            cmd_command  <= '0;
            cmd_argument <= '0;
            cmd_rx_byte  <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_if.ready)
            begin
                predict_frames_and_status(on_bus);
                items_taken = items_taken + 1;
            end
            if (!cmd_valid || cmd_if.ready)
            begin
                if (link_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = link_items.pop_front();
                    cmd_valid    <= 1'b1;
                    cmd_opcode   <= on_bus.opcode;
                    cmd_command  <= on_bus.command;
                    cmd_argument <= on_bus.argument;
                    cmd_rx_byte  <= on_bus.rx_byte;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        player_result_t want;
        if (rst_n && res_if.valid && res_ready)
        begin
            if (due_outcomes.size() == 0)
            begin
                $error("result with nothing due: kind %0d tx %0h last %0d status %0d attempts %0d",
                       res_if.result_kind, res_if.tx_byte, res_if.frame_last, res_if.status,
                       res_if.attempts_used);
                fault_count = fault_count + 1;
            end
            else
            begin
                want = due_outcomes.pop_front();
                if (res_if.result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, res_if.result_kind);
                    fault_count = fault_count + 1;
                end
                if (res_if.tx_byte !== want.tx)
                begin
                    $error("tx_byte: expected %0h, actual %0h", want.tx, res_if.tx_byte);
                    fault_count = fault_count + 1;
                end
                if (res_if.frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, actual %0d", want.last, res_if.frame_last);
                    fault_count = fault_count + 1;
                end
                if (res_if.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, res_if.status);
                    fault_count = fault_count + 1;
                end
                if (res_if.attempts_used !== want.attempts)
                begin
                    $error("attempts_used: expected %0d, actual %0d", want.attempts,
                           res_if.attempts_used);
                    fault_count = fault_count + 1;
                end
            end
        end
    end

    task automatic queue_item(input logic [1:0] op, input logic [2:0] command,
                              input logic [15:0] argument, input logic [7:0] rx);
        link_item_t it;
        it.opcode   = op;
        it.command  = command;
        it.argument = argument;
        it.rx_byte  = rx;
        link_items.push_back(it);
        items_queued = items_queued + 1;
    endtask

    task automatic queue_request(input logic [2:0] command, input logic [15:0] argument);
        queue_item(OP_REQUEST, command, argument, 8'($urandom));
    endtask

    task automatic queue_rx(input logic [7:0] rx);
        queue_item(OP_RX_BYTE, 3'($urandom), 16'($urandom), rx);
    endtask

    task automatic queue_ack();
        queue_rx(ACK_FIRST);
        queue_rx(ACK_SECOND);
    endtask

    task automatic queue_ticks(input int n);
        int i;
        for (i = 0; i < n; i++)
            queue_item(OP_TICK, 3'($urandom), 16'($urandom), 8'($urandom));
    endtask

    function automatic int ticks_to_failure();
        int per_try;
        per_try = ((reg_timeout == 10'd0) ? 1 : int'(reg_timeout)) + int'(reg_gap);
        return int'(reg_retries) * per_try;
    endfunction

    function automatic logic [15:0] pick_argument();
        logic [15:0] a;
        case ($urandom_range(5))
            0: a = 16'd0;
            1: a = 16'hFFFF;
            2: a = 16'($urandom_range(40));
            3: a = 16'($urandom_range(6));
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    // Waits until every queued item is taken, brings the player back to idle and lets
    // the last results drain.
    task automatic settle();
        while (items_taken != items_queued)
            @(negedge clk);
        while (link_phase != LINK_IDLE)
        begin
            if (link_phase == LINK_WAIT)
                queue_ack();
            else
                queue_ticks((link_timer == 10'd0) ? 1 : int'(link_timer));
            while (items_taken != items_queued)
                @(negedge clk);
        end
        while (due_outcomes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_ACK_ENABLED: reg_ack_en  = value[0];
            CFG_MAX_RETRIES: reg_retries = value[3:0];
            CFG_ACK_TIMEOUT: reg_timeout = value[9:0];
            CFG_RETRY_GAP:   reg_gap     = value[9:0];
            CFG_MIN_VOLUME:  reg_min_vol = value[4:0];
            CFG_MAX_VOLUME:  reg_max_vol = value[4:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_setting(input int idx);
        int ack;
        int retries;
        int timeout;
        int gap;
        int min_vol;
        int max_vol;
        case (idx)
            0:       {ack, retries, timeout, gap, min_vol, max_vol} = {32'd1, 32'd3, 32'd4,
                                                                        32'd2, 32'd0, 32'd30};
            1:       {ack, retries, timeout, gap, min_vol, max_vol} = {32'd1, 32'd15, 32'd1,
                                                                        32'd0, 32'd5, 32'd20};
            2:       {ack, retries, timeout, gap, min_vol, max_vol} = {32'd0, 32'd1, 32'd3,
                                                                        32'd1, 32'd30, 32'd30};
            3:       {ack, retries, timeout, gap, min_vol, max_vol} = {32'd1, 32'd1, 32'd1023,
                                                                        32'd1023, 32'd30, 32'd0};
            4:       {ack, retries, timeout, gap, min_vol, max_vol} = {32'd1, 32'd0, 32'd2,
                                                                        32'd0, 32'd0, 32'd0};
            default: {ack, retries, timeout, gap, min_vol, max_vol} = {32'd1, 32'd2, 32'd0,
                                                                        32'd5, 32'd10, 32'd12};
        endcase
        write_reg(CFG_ACK_ENABLED, ack);
        write_reg(CFG_MAX_RETRIES, retries);
        write_reg(CFG_ACK_TIMEOUT, timeout);
        write_reg(CFG_RETRY_GAP, gap);
        write_reg(CFG_MIN_VOLUME, min_vol);
        write_reg(CFG_MAX_VOLUME, max_vol);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_traffic(input int count);
        int made;
        int n;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 70)
            begin
                queue_request(3'($urandom_range(7)), pick_argument());
                made = made + 1;
                case ($urandom_range(4))
                    0:
                    begin
                        queue_ack();
                        made = made + 2;
                    end
                    1:
                    begin
                        queue_rx(8'($urandom));
                        queue_rx(ACK_FIRST);
                        queue_ack();
                        made = made + 4;
                    end
                    2:
                    begin
                        queue_rx(ACK_FIRST);
                        queue_rx(8'($urandom_range(254)));
                        queue_rx(ACK_SECOND);
                        n = ((reg_timeout == 10'd0) ? 1 : int'(reg_timeout)) + 1;
                        queue_ticks($urandom_range(1, (n > TICK_BURST) ? TICK_BURST : n));
                        queue_ack();
                        made = made + 6;
                    end
                    3:
                    begin
                        n = ticks_to_failure() + 1;
                        queue_ticks($urandom_range(1, (n > TICK_BURST) ? TICK_BURST : n));
                        queue_request(3'($urandom_range(7)), pick_argument());
                        queue_ack();
                        made = made + 4;
                    end
                    default:
                    begin
                        queue_request(3'($urandom_range(7)), pick_argument());
                        queue_ack();
                        made = made + 3;
                    end
                endcase
            end
            else
            begin
                queue_item(2'($urandom_range(3)), 3'($urandom), 16'($urandom),
                           ($urandom_range(3) == 0) ? ACK_FIRST : 8'($urandom));
                made = made + 1;
            end
        end
    endtask

    initial
    begin
        int stage;
        int p;
        int fail_ticks;
        send_idle_pct = 7;
        recv_idle_pct = 84;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_request(CMD_PLAY, 16'd0);
        queue_ack();
        queue_request(CMD_PLAY, 16'hFFFF);
        queue_rx(8'h12);
        queue_rx(ACK_FIRST);
        queue_ack();
        queue_request(CMD_STOP, 16'd0);
        queue_request(CMD_VOLUME, 16'd5);
        queue_ack();
        queue_request(CMD_VOLUME, 16'd31);
        queue_ack();
        queue_request(CMD_FAST_VOLUME, 16'd30);
        queue_request(CMD_FAST_VOLUME, 16'd0);
        queue_request(CMD_LOOP_SINGLE, 16'd0);
        queue_rx(ACK_SECOND);
        queue_ack();
        queue_request(CMD_LOOP_OFF, 16'hFFFF);
        queue_ack();
        queue_request(CMD_EQ, 16'd5);
        queue_ack();
        queue_request(CMD_EQ, EQ_MAX_CODE);
        queue_ack();
        queue_request(CMD_SELECT_CARD, 16'd0);
        queue_ticks(3);
        queue_ack();
        queue_rx(ACK_FIRST);
        queue_rx(ACK_SECOND);
        queue_ticks(1);
        queue_item(OP_UNUSED, CMD_PLAY, 16'd0, ACK_FIRST);
        settle();

        for (stage = 0; stage < 3; stage++)
        begin
            send_idle_pct = (stage == 0) ? 7 : ((stage == 1) ? 84 : 0);
            recv_idle_pct = (stage == 0) ? 84 : ((stage == 1) ? 7 : 0);
            for (p = 0; p < 2; p++)
            begin
                apply_setting(stage * 2 + p);
                queue_request(CMD_STOP, 16'($urandom));
                fail_ticks = ticks_to_failure();
                queue_ticks((fail_ticks > TICK_BURST) ? TICK_BURST : fail_ticks);
                queue_traffic(SEQ_PER_PHASE);
                settle();
            end
        end

        if (fault_count == 0 && due_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
design/pcf_pkg.sv
design/pcf_chan_if.sv
design/pcf_front.sv
design/pcf_queue.sv
design/pcf_back.sv
design/player_command_framer_with_ack_top.sv
tb/sv/tb_top.sv
